>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared widths, limits and handshake types for the abundant number tester.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

    localparam int NUMBER_W = 20;
    localparam int SUM_W    = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
        logic exact;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/abundant_number_test_unit.sv
// ----------------------------------------------------------------------------
// abundant_number_test_unit
// Trial-division abundance test with a saturating sum of the divisors other than 1 and n.
// Each trial divisor takes a compare state (ST_CHECK) and then a run of the shared
// divider (ST_DIV); the divider works on N_W = min(NUM_BITS, 20) bits.
// One item in flight; the next is taken while a result waits in the output register.
// Reset clears the sequencer and output valid; no memories to clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module abundant_number_test_unit
    import abt_pkg::*;
#(
    parameter int NUM_BITS = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [NUMBER_W-1:0] number,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     abundant,
    output logic [SUM_W-1:0]         divisor_sum
);

    localparam int N_W  = (NUM_BITS < NUMBER_W) ? NUM_BITS : NUMBER_W;
    localparam int D_W  = (N_W + 1) / 2 + 1;
    localparam int SQ_W = N_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [N_W-1:0]   n_reg;
    logic [D_W-1:0]   d_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [SUM_W-1:0] acc_reg;
    logic             out_valid_reg;
    logic             abundant_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             sq_lt;
    logic             div_start;
    logic [N_W-1:0]   div_q;
    div_stat_t        div_stat;
    logic [SUM_W:0]   pair_sum;
    logic [SUM_W:0]   root_sum;
    logic [SUM_W-1:0] pair_sat;
    logic [SUM_W-1:0] root_sat;
    logic [SQ_W-1:0]  sq_next;

    always_comb
    begin
        sq_lt     = (sq_reg < SQ_W'(n_reg));
        div_start = (state_reg == ST_CHECK) && sq_lt;
        pair_sum  = {1'b0, acc_reg} + (SUM_W+1)'(d_reg) + (SUM_W+1)'(div_q);
        root_sum  = {1'b0, acc_reg} + (SUM_W+1)'(d_reg);
        pair_sat  = pair_sum[SUM_W] ? SUM_MAX : pair_sum[SUM_W-1:0];
        root_sat  = root_sum[SUM_W] ? SUM_MAX : root_sum[SUM_W-1:0];
        sq_next   = sq_reg + SQ_W'({d_reg, 1'b0}) + SQ_W'(1);
    end

    abt_divider #(
        .N_W (N_W),
        .D_W (D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            d_reg         <= '0;
            sq_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            abundant_reg  <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg     <= number[N_W-1:0];
                        d_reg     <= D_W'(2);
                        sq_reg    <= SQ_W'(4);
                        acc_reg   <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= sq_lt ? ST_DIV : ST_FIN;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_stat.exact)
                        begin
                            acc_reg <= pair_sat;
                        end
                        d_reg     <= d_reg + 1'b1;
                        sq_reg    <= sq_next;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FIN:
                begin
                    if (sq_reg == SQ_W'(n_reg))
                    begin
                        acc_reg <= root_sat;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        abundant_reg  <= (acc_reg > SUM_W'(n_reg));
                        sum_reg       <= acc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign abundant    = abundant_reg;
    assign divisor_sum = sum_reg;

    `ASSERT_IMPLY(a_start_free, clk, rst_n, div_start, !div_stat.busy)
    `ASSERT_NEXT(a_divisor_hold, clk, rst_n, (state_reg == ST_DIV) && !div_stat.done, $stable(d_reg))
    `ASSERT_IMPLY(a_square_track, clk, rst_n, state_reg != ST_IDLE, sq_reg == SQ_W'(d_reg) * SQ_W'(d_reg))

endmodule

`default_nettype wire

>>> hw/rtl/abt_divider.sv
// ----------------------------------------------------------------------------
// abt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_divider
    import abt_pkg::*;
#(
    parameter int N_W = 20,
    parameter int D_W = 11
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic [N_W-1:0]      quotient,
    output div_stat_t           stat
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   work_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [D_W:0]     trial;
    logic             fits;
    logic [D_W:0]     diff;

    always_comb
    begin
        trial = {rem_reg, work_reg[N_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                work_reg <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= {work_reg[N_W-2:0], fits};
                rem_reg  <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient   = work_reg;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.exact = (rem_reg == '0);

endmodule

`default_nettype wire
